@@ src/ctlr_pkg.sv @@
// shared constants, types and state encoding for the cache tag directory
package ctlr_pkg;

	localparam int CAPACITY_LOG2   = 17;
	localparam int MIN_OFFSET_BITS = 3;
	localparam int MAX_WAYS        = 8;

	localparam int LINE_W       = CAPACITY_LOG2 - MIN_OFFSET_BITS;
	localparam int MAX_LINES    = 1 << LINE_W;
	localparam int ADDR_W       = 64;
	localparam int TAG_W        = ADDR_W - MIN_OFFSET_BITS;
	localparam int LOG_W        = $clog2(LINE_W + 1);
	localparam int SH_W         = $clog2(CAPACITY_LOG2 + 1);
	localparam int MAX_WAY_LOG2 = (MAX_WAYS >= 8) ? 3 : 2;
	localparam int PADDR_W      = 4;
	localparam int DATA_W       = 32;
	localparam int LFSR_W       = 16;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

	localparam logic [1:0] MAP_DIRECT = 2'd0;
	localparam logic [1:0] MAP_FULL   = 2'd1;
	localparam logic [1:0] MAP_WAY4   = 2'd2;
	localparam logic [1:0] MAP_WAY8   = 2'd3;

	localparam logic [1:0] POL_LRU    = 2'd0;
	localparam logic [1:0] POL_RANDOM = 2'd1;

	localparam logic [2:0] OFFSET_RST  = 3'd3;
	localparam logic [1:0] MAPPING_RST = MAP_WAY8;
	localparam logic [1:0] POLICY_RST  = POL_LRU;
	localparam logic [1:0] WPOLICY_RST = 2'd1;

	typedef enum logic [1:0] {
		REG_OFFSET,
		REG_MAPPING,
		REG_POLICY,
		REG_WRITE
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_REPL,
		ST_LRU,
		ST_TREE_RD,
		ST_TREE_WR,
		ST_WRITE,
		ST_RESP
	} state_t;

	// decoded geometry and policy, plus the flush strobe of a register write
	typedef struct packed {
		logic [2:0]       off;
		logic [LOG_W-1:0] ll;
		logic [LOG_W-1:0] glog;
		logic [1:0]       mode;
		logic [1:0]       pol;
		logic [1:0]       wpol;
		logic             flush;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [TAG_W-1:0] tag;
	} tag_entry_t;

endpackage

@@ src/cache_tag_lookup_replacement.sv @@
// steps: accept, tag scan over the ways (all lines when fully associative),
// replacement decision, replacement update (lru stack shift, tree walk and update
// for a victim or update only for a visit, none for random), tag write, result
// one access at a time
// scan and lru shift are bounded by the single read port of the tag and stack rams
// after reset and after every register write a clearing pass blocks transfers
module cache_tag_lookup_replacement (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ctlr_pkg::PADDR_W-1:0] paddr,
	input  logic [ctlr_pkg::DATA_W-1:0]  pwdata,
	output logic [ctlr_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [ctlr_pkg::ADDR_W-1:0]  address,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic                         filled,
	output logic [ctlr_pkg::LINE_W-1:0]  line_index
);
	import ctlr_pkg::*;

	cfg_t cfg;

	ctlr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctlr_dir u_dir (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.address    (address),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.filled     (filled),
		.line_index (line_index)
	);

	a_hit_excl_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && filled))
		else $error("hit and fill reported together");

	a_idle_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit && !filled) |-> (line_index == '0))
		else $error("line index nonzero without hit or fill");

	a_flush_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) |=> !in_ready)
		else $error("access taken during clearing pass");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second access taken while busy");
endmodule

@@ src/ctlr_ram.sv @@
// generic single write port, single read port ram with registered read
module ctlr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ src/ctlr_cfg.sv @@
// apb register file and geometry decode
module ctlr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ctlr_pkg::PADDR_W-1:0]  paddr,
	input  logic [ctlr_pkg::DATA_W-1:0]   pwdata,
	output logic [ctlr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output ctlr_pkg::cfg_t                cfg
);
	import ctlr_pkg::*;

	logic [2:0] offset_bits_q;
	logic [1:0] mapping_mode_q;
	logic [1:0] repl_policy_q;
	logic [1:0] write_policy_q;
	logic       wr_en;
	reg_idx_t   idx;
	logic [2:0] eff_off;
	logic [LOG_W-1:0] ll;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q  <= OFFSET_RST;
			mapping_mode_q <= MAPPING_RST;
			repl_policy_q  <= POLICY_RST;
			write_policy_q <= WPOLICY_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_OFFSET:  offset_bits_q  <= pwdata[2:0];
				REG_MAPPING: mapping_mode_q <= pwdata[1:0];
				REG_POLICY:  repl_policy_q  <= pwdata[1:0];
				REG_WRITE:   write_policy_q <= pwdata[1:0];
				default:     offset_bits_q  <= offset_bits_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_OFFSET:  prdata = DATA_W'(offset_bits_q);
			REG_MAPPING: prdata = DATA_W'(mapping_mode_q);
			REG_POLICY:  prdata = DATA_W'(repl_policy_q);
			REG_WRITE:   prdata = DATA_W'(write_policy_q);
			default:     prdata = '0;
		endcase
	end

	// small blocks are raised to the minimum block size
	assign eff_off = (offset_bits_q < 3'(MIN_OFFSET_BITS)) ? 3'(MIN_OFFSET_BITS)
		: offset_bits_q;
	assign ll = LOG_W'(CAPACITY_LOG2 - int'(eff_off));

	always_comb begin
		cfg.off   = eff_off;
		cfg.ll    = ll;
		cfg.mode  = mapping_mode_q;
		cfg.pol   = repl_policy_q;
		cfg.wpol  = write_policy_q;
		cfg.flush = wr_en;
		unique case (mapping_mode_q)
			MAP_DIRECT: cfg.glog = '0;
			MAP_FULL:   cfg.glog = ll;
			MAP_WAY4:   cfg.glog = LOG_W'(2);
			MAP_WAY8:   cfg.glog = LOG_W'(MAX_WAY_LOG2);
			default:    cfg.glog = '0;
		endcase
	end
endmodule

@@ src/ctlr_dir.sv @@
// tag directory sequencer: way scan, replacement update and line fill
module ctlr_dir (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctlr_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [ctlr_pkg::ADDR_W-1:0]  address,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic                         filled,
	output logic [ctlr_pkg::LINE_W-1:0]  line_index
);
	import ctlr_pkg::*;

	state_t state_q, state_d;

	logic [LINE_W-1:0] clr_q;
	logic [LINE_W-1:0] last_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic              out_valid_q;
	logic              res_hit_q;
	logic              res_filled_q;
	logic [LINE_W-1:0] res_line_q;

	logic [TAG_W-1:0]  tag_q;
	logic [LINE_W-1:0] base_q;
	logic              mark_q;
	logic              fill_ok_q;
	logic              hit_q;
	logic              free_q;
	logic              vict_q;
	logic [LINE_W-1:0] x_q;
	logic [LINE_W:0]   issue_q;
	logic              pend_q;
	logic [LINE_W-1:0] pway_q;
	logic [LINE_W:0]   node_q;
	logic [LOG_W-1:0]  step_q;
	logic              phase_q;

	// ram ports
	logic              tag_we, stk_we, plru_we;
	logic [LINE_W-1:0] tag_waddr, tag_raddr, stk_waddr, stk_raddr, plru_waddr, plru_raddr;
	tag_entry_t        tag_wdata, ent;
	logic [TAG_W+1:0]  tag_rdata;
	logic [LINE_W-1:0] stk_wdata, stk_rdata;
	logic              plru_wdata, plru_rdata;

	// geometry and per-item values
	logic [LINE_W-1:0] lmask, gm, smask, a_line, base_c, way_now, line_c;
	logic [LINE_W-1:0] vic_c, new_x;
	logic [LOG_W-1:0]  sl;
	logic [SH_W-1:0]   tag_sh;
	logic [ADDR_W-1:0] a_sh;
	logic [LINE_W:0]   size, node_nx, p_c;
	logic [LFSR_W-1:0] lfsr_nx;
	logic              accept, issue_done, match, scan_end, free_c;
	logic              act, vict_c, lru_stop, walk_done, out_load;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !cfg.flush;
	assign out_load = !out_valid_q || out_ready;

	assign lmask = ~({LINE_W{1'b1}} << cfg.ll);
	assign gm    = ~({LINE_W{1'b1}} << cfg.glog);
	assign size  = {1'b0, gm} + (LINE_W+1)'(1);
	assign sl    = cfg.ll - cfg.glog;
	assign smask = ~({LINE_W{1'b1}} << sl);

	assign a_sh   = address >> cfg.off;
	assign a_line = a_sh[LINE_W-1:0];
	assign base_c = (cfg.mode == MAP_FULL) ? '0 : ((a_line & smask) << cfg.glog);

	always_comb begin
		unique case (cfg.mode)
			MAP_DIRECT: tag_sh = SH_W'(CAPACITY_LOG2);
			MAP_FULL:   tag_sh = SH_W'(cfg.off);
			default:    tag_sh = SH_W'(CAPACITY_LOG2) - SH_W'(cfg.glog);
		endcase
	end

	// scan: one tag read issued per cycle, compared in the cycle after it is issued
	assign ent        = tag_entry_t'(tag_rdata);
	assign issue_done = (issue_q == size);
	assign way_now    = (cfg.mode == MAP_FULL) ? ((last_q + issue_q[LINE_W-1:0]) & lmask)
		: issue_q[LINE_W-1:0];
	assign match      = pend_q && ent.valid && (ent.tag == tag_q);
	assign scan_end   = match || (pend_q && issue_done);
	assign free_c     = free_q || (pend_q && !ent.valid);
	assign vic_c      = (pend_q && !ent.valid && !free_q) ? pway_q : x_q;

	assign act    = hit_q || fill_ok_q;
	assign vict_c = !hit_q && !free_q;

	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	// lru stack shift stops at the visited entry, or at the bottom for a victim
	assign lru_stop = pend_q && (vict_q ? (pway_q == gm) : (stk_rdata == x_q));

	assign new_x     = {x_q[LINE_W-2:0], plru_rdata};
	assign node_nx   = (node_q << 1) + (LINE_W+1)'(plru_rdata) + (LINE_W+1)'(1);
	assign walk_done = (step_q == cfg.glog - LOG_W'(1));
	assign p_c       = (node_q - (LINE_W+1)'(1)) >> 1;

	assign line_c = base_q + (x_q & gm);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == LINE_W'(MAX_LINES - 1)) state_d = ST_IDLE;
			ST_IDLE:    if (accept) state_d = ST_SCAN;
			ST_SCAN:    if (scan_end) state_d = ST_REPL;
			ST_REPL: begin
				if (!act) state_d = ST_RESP;
				else if (cfg.mode == MAP_DIRECT) state_d = ST_WRITE;
				else if (cfg.pol == POL_LRU) state_d = ST_LRU;
				else if (cfg.pol == POL_RANDOM) state_d = ST_WRITE;
				else if (vict_c) state_d = ST_TREE_RD;
				else state_d = ST_TREE_WR;
			end
			ST_LRU:     if (lru_stop) state_d = ST_WRITE;
			ST_TREE_RD: if (phase_q && walk_done) state_d = ST_TREE_WR;
			ST_TREE_WR: if (p_c == '0) state_d = ST_WRITE;
			ST_WRITE:   state_d = ST_RESP;
			ST_RESP:    if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_CLEAR;
		endcase
		if (cfg.flush) state_d = ST_CLEAR;
	end

	always_comb begin
		tag_we     = 1'b0;
		tag_waddr  = line_c;
		tag_wdata  = '{valid: 1'b1, dirty: mark_q, tag: tag_q};
		tag_raddr  = base_q + way_now;
		stk_we     = 1'b0;
		stk_waddr  = base_q + pway_q + LINE_W'(1);
		stk_wdata  = stk_rdata;
		stk_raddr  = base_q + issue_q[LINE_W-1:0];
		plru_we    = 1'b0;
		plru_waddr = base_q + p_c[LINE_W-1:0];
		plru_wdata = node_q[0];
		plru_raddr = base_q + node_q[LINE_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				tag_we     = 1'b1;
				tag_waddr  = clr_q;
				tag_wdata  = '0;
				stk_we     = 1'b1;
				stk_waddr  = clr_q;
				stk_wdata  = clr_q & gm;
				plru_we    = 1'b1;
				plru_waddr = clr_q;
				plru_wdata = 1'b0;
			end
			ST_LRU: begin
				stk_we = pend_q;
				if (lru_stop) stk_waddr = base_q;
			end
			ST_TREE_WR: plru_we = 1'b1;
			ST_WRITE:   tag_we = (fill_ok_q && !hit_q) || (hit_q && mark_q);
			default:    tag_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			last_q      <= '0;
			lfsr_q      <= LFSR_SEED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.flush) begin
				clr_q  <= '0;
				last_q <= '0;
				lfsr_q <= LFSR_SEED;
			end else begin
				if (state_q == ST_CLEAR) clr_q <= clr_q + LINE_W'(1);
				if (state_q == ST_REPL && act && hit_q && cfg.mode == MAP_FULL) last_q <= x_q;
				if (state_q == ST_REPL && act && cfg.mode != MAP_DIRECT
					&& cfg.pol == POL_RANDOM && vict_c) lfsr_q <= lfsr_nx;
			end
			if (state_q == ST_RESP && out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				tag_q     <= TAG_W'(address >> tag_sh);
				base_q    <= base_c;
				mark_q    <= opcode && (cfg.wpol == 2'd1 || cfg.wpol == 2'd2);
				fill_ok_q <= !opcode || cfg.wpol[0];
				issue_q   <= '0;
				pend_q    <= 1'b0;
				free_q    <= 1'b0;
				hit_q     <= 1'b0;
				x_q       <= '0;
			end
			ST_SCAN: begin
				if (!issue_done) issue_q <= issue_q + (LINE_W+1)'(1);
				pend_q <= !issue_done;
				pway_q <= way_now;
				free_q <= free_c;
				hit_q  <= match;
				x_q    <= match ? pway_q : vic_c;
			end
			ST_REPL: begin
				issue_q <= '0;
				pend_q  <= 1'b0;
				vict_q  <= vict_c;
				step_q  <= '0;
				phase_q <= 1'b0;
				if (act && cfg.mode != MAP_DIRECT && cfg.pol != POL_LRU) begin
					if (cfg.pol == POL_RANDOM) begin
						if (vict_c) x_q <= lfsr_nx[LINE_W-1:0] & gm;
					end else if (vict_c) begin
						node_q <= '0;
						x_q    <= '0;
					end else begin
						node_q <= {1'b0, x_q} + {1'b0, gm};
					end
				end
			end
			ST_LRU: begin
				issue_q <= issue_q + (LINE_W+1)'(1);
				pend_q  <= 1'b1;
				pway_q  <= issue_q[LINE_W-1:0];
				if (lru_stop && vict_q) x_q <= stk_rdata & gm;
			end
			ST_TREE_RD: begin
				phase_q <= !phase_q;
				if (phase_q) begin
					x_q    <= new_x;
					step_q <= step_q + LOG_W'(1);
					node_q <= walk_done ? ({1'b0, new_x} + {1'b0, gm}) : node_nx;
				end
			end
			ST_TREE_WR: node_q <= p_c;
			ST_RESP: if (out_load) begin
				res_hit_q    <= hit_q;
				res_filled_q <= !hit_q && fill_ok_q;
				res_line_q   <= act ? line_c : '0;
			end
			default: pend_q <= pend_q;
		endcase
	end

	ctlr_ram #(.WIDTH(TAG_W + 2), .DEPTH(MAX_LINES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	ctlr_ram #(.WIDTH(LINE_W), .DEPTH(MAX_LINES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	ctlr_ram #(.WIDTH(1), .DEPTH(MAX_LINES)) u_plru_ram (
		.clk   (clk),
		.we    (plru_we),
		.waddr (plru_waddr),
		.wdata (plru_wdata),
		.raddr (plru_raddr),
		.rdata (plru_rdata)
	);

	assign out_valid  = out_valid_q;
	assign hit        = res_hit_q;
	assign filled     = res_filled_q;
	assign line_index = res_line_q;
endmodule

@@ bench/cache_tag_lookup_replacement_checker.sv @@
// checker: tracks the directory state, predicts each lookup and compares results
`timescale 1ns / 100ps
module cache_tag_lookup_replacement_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ctlr_pkg::PADDR_W-1:0] paddr,
	input  logic [ctlr_pkg::DATA_W-1:0]  pwdata,
	input  logic                         pready,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         opcode,
	input  logic [ctlr_pkg::ADDR_W-1:0]  address,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         hit,
	input  logic                         filled,
	input  logic [ctlr_pkg::LINE_W-1:0]  line_index,
	output int                           errors,
	output int                           pending
);
	import ctlr_pkg::*;

	typedef struct {
		logic              hit;
		logic              filled;
		logic [LINE_W-1:0] line;
	} lookup_t;

	lookup_t lookup_q[$];

	logic [2:0] cfg_off;
	logic [1:0] cfg_mode;
	logic [1:0] cfg_pol;
	logic [1:0] cfg_wpol;

	logic [63:0]     dir_tag[MAX_LINES];
	bit              dir_valid[MAX_LINES];
	bit              dir_dirty[MAX_LINES];
	int unsigned     stack[MAX_LINES];
	bit              tree[MAX_LINES];
	int unsigned     mru_line;
	logic [15:0]     lfsr;

	assign pending = lookup_q.size();

	function automatic int unsigned eff_off();
		return (cfg_off < MIN_OFFSET_BITS) ? MIN_OFFSET_BITS : cfg_off;
	endfunction

	function automatic int unsigned grp_log2();
		if (cfg_mode == MAP_DIRECT) return 0;
		if (cfg_mode == MAP_FULL) return CAPACITY_LOG2 - eff_off();
		if (cfg_mode == MAP_WAY4) return 2;
		return MAX_WAY_LOG2;
	endfunction

	task automatic flush_dir();
		int unsigned gmask;
		gmask = (1 << grp_log2()) - 1;
		for (int k = 0; k < MAX_LINES; k++) begin
			dir_valid[k] = 0;
			dir_dirty[k] = 0;
			dir_tag[k] = '0;
			tree[k] = 0;
			stack[k] = k & gmask;
		end
		mru_line = 0;
		lfsr = LFSR_SEED;
	endtask

	task automatic stack_to_top(int unsigned base, int unsigned pos);
		int unsigned v;
		v = stack[base + pos];
		for (int unsigned i = pos; i > 0; i--) stack[base + i] = stack[base + i - 1];
		stack[base] = v;
	endtask

	task automatic tree_touch(int unsigned base, int unsigned size, int unsigned leaf);
		int unsigned n, p;
		if (size < 2) return;
		n = leaf + size - 1;
		do begin
			p = (n - 1) >> 1;
			tree[(base + p) & (MAX_LINES - 1)] = n[0];
			n = p;
		end while (p > 0);
	endtask

	task automatic touch(int unsigned base, int unsigned size, int unsigned x);
		if (cfg_pol == POL_LRU) begin
			for (int unsigned i = 0; i < size; i++)
				if (stack[base + i] == x) begin
					stack_to_top(base, i);
					break;
				end
		end else if (cfg_pol != POL_RANDOM) begin
			tree_touch(base, size, x);
		end
	endtask

	task automatic pick_victim(int unsigned base, int unsigned size, int unsigned glog,
			output int unsigned victim);
		int unsigned v, n, m;
		v = 0;
		n = 0;
		if (cfg_pol == POL_LRU) begin
			stack_to_top(base, size - 1);
			victim = stack[base] & (size - 1);
		end else if (cfg_pol == POL_RANDOM) begin
			lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
			victim = lfsr & (size - 1);
		end else begin
			for (int unsigned i = 0; i < glog; i++) begin
				m = tree[(base + n) & (MAX_LINES - 1)];
				v = (v << 1) + m;
				n = (n << 1) + m + 1;
			end
			tree_touch(base, size, v);
			victim = v;
		end
	endtask

	task automatic predict_lookup(logic wr, logic [63:0] addr, output lookup_t r);
		int unsigned off, ll, lines, base, size, glog, victim, way, sl, idx;
		bit may_fill, mark, have_free;
		logic [63:0] tag;
		off = eff_off();
		ll = CAPACITY_LOG2 - off;
		lines = 1 << ll;
		may_fill = !wr || cfg_wpol[0];
		mark = wr && (cfg_wpol == 2'd1 || cfg_wpol == 2'd2);
		r.hit = 0;
		r.filled = 0;
		r.line = '0;
		have_free = 0;
		victim = 0;
		if (cfg_mode == MAP_DIRECT) begin
			idx = (addr >> off) & (lines - 1);
			tag = addr >> CAPACITY_LOG2;
			if (dir_valid[idx] && dir_tag[idx] == tag) begin
				r.hit = 1;
				r.line = idx;
				if (mark) dir_dirty[idx] = 1;
			end else if (may_fill) begin
				dir_tag[idx] = tag;
				dir_valid[idx] = 1;
				dir_dirty[idx] = mark;
				r.filled = 1;
				r.line = idx;
			end
		end else begin
			if (cfg_mode == MAP_FULL) begin
				glog = ll;
				base = 0;
				tag = addr >> off;
			end else begin
				glog = grp_log2();
				sl = ll - glog;
				base = ((addr >> off) & ((1 << sl) - 1)) << glog;
				tag = addr >> (off + sl);
			end
			size = 1 << glog;
			for (int unsigned i = 0; i < size; i++) begin
				way = (cfg_mode == MAP_FULL) ? ((mru_line + i) & (lines - 1)) : i;
				if (dir_valid[base + way]) begin
					if (dir_tag[base + way] == tag) begin
						r.hit = 1;
						r.line = base + way;
						if (mark) dir_dirty[base + way] = 1;
						if (cfg_mode == MAP_FULL) mru_line = way;
						touch(base, size, way);
						break;
					end
				end else if (!have_free) begin
					have_free = 1;
					victim = way;
				end
			end
			if (!r.hit && may_fill) begin
				if (!have_free) pick_victim(base, size, glog, victim);
				else touch(base, size, victim);
				idx = base + (victim & (size - 1));
				dir_tag[idx] = tag;
				dir_valid[idx] = 1;
				dir_dirty[idx] = mark;
				r.filled = 1;
				r.line = idx;
			end
		end
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		cfg_off = OFFSET_RST;
		cfg_mode = MAPPING_RST;
		cfg_pol = POLICY_RST;
		cfg_wpol = WPOLICY_RST;
		flush_dir();
	end

	always @(posedge clk) begin
		lookup_t r, e;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_OFFSET:  cfg_off = pwdata[2:0];
					REG_MAPPING: cfg_mode = pwdata[1:0];
					REG_POLICY:  cfg_pol = pwdata[1:0];
					REG_WRITE:   cfg_wpol = pwdata[1:0];
				endcase
				flush_dir();
			end
			if (out_valid && out_ready) begin
				if (lookup_q.size() == 0) begin
					report("unexpected result", line_index, 0);
				end else begin
					e = lookup_q.pop_front();
					if (hit !== e.hit) report("hit", hit, e.hit);
					if (filled !== e.filled) report("filled", filled, e.filled);
					if (line_index !== e.line) report("line_index", line_index, e.line);
				end
			end
			if (in_valid && in_ready) begin
				predict_lookup(opcode, address, r);
				lookup_q.push_back(r);
			end
		end
	end
endmodule

@@ bench/cache_tag_lookup_replacement_tb.sv @@
// testbench top: drives configuration and accesses, gives the verdict
`timescale 1ns / 100ps
module cache_tag_lookup_replacement_tb;
	import ctlr_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid, in_ready, opcode;
	logic [ADDR_W-1:0]  address;
	logic               out_valid, out_ready, hit, filled;
	logic [LINE_W-1:0]  line_index;
	int                 errors, pending;

	bit   quiet;
	bit   hold_req;
	int   cur_off;
	logic [2:0] cur_cfg[4];
	logic [63:0] hi_pool[10];

	cache_tag_lookup_replacement u_top (.*);

	cache_tag_lookup_replacement_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#40_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		int hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 7);
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = PADDR_W'(idx) << 2;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apply_cfg(logic [2:0] off, logic [1:0] mode, logic [1:0] pol,
			logic [1:0] wpol);
		logic [2:0] want[4];
		want = '{off, 3'(mode), 3'(pol), 3'(wpol)};
		wait (pending == 0);
		repeat (20) @(negedge clk);
		for (int i = 0; i < 4; i++)
			if (want[i] !== cur_cfg[i]) begin
				reg_write(reg_idx_t'(i), DATA_W'(want[i]));
				cur_cfg[i] = want[i];
			end
		cur_off = (off < MIN_OFFSET_BITS) ? MIN_OFFSET_BITS : off;
		for (int i = 0; i < 10; i++) hi_pool[i] = {$urandom, $urandom};
	endtask

	// ready is stable from the falling edge on, so the transfer edge is known here
	task automatic send(logic op, logic [63:0] addr);
		in_valid = 1'b1;
		opcode = op;
		address = addr;
		while (!in_ready) @(negedge clk);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < 7) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// mostly a few tags over a few sets so hits and evictions are common
	function automatic logic [63:0] gen_addr();
		logic [63:0] a;
		a = {$urandom, $urandom};
		if ($urandom_range(0, 99) < 15) return a;
		a = hi_pool[$urandom_range(0, 9)] & ~64'h1_FFFF;
		a |= 64'($urandom_range(0, 3)) << cur_off;
		a |= 64'($urandom) & ((64'd1 << cur_off) - 1);
		return a;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) send($urandom_range(0, 1), gen_addr());
		in_valid = 1'b0;
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		opcode = 1'b0;
		address = '0;
		quiet = 0;
		hold_req = 0;
		cur_off = OFFSET_RST;
		cur_cfg = '{OFFSET_RST, 3'(MAPPING_RST), 3'(POLICY_RST), 3'(WPOLICY_RST)};
		for (int i = 0; i < 10; i++) hi_pool[i] = {$urandom, $urandom};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed accesses on the reset setting
		send(1'b0, 64'h0);
		send(1'b0, 64'h0);
		send(1'b1, 64'h0);
		send(1'b0, '1);
		send(1'b1, '1);
		send(1'b0, 64'h8000_0000_0000_0000);
		send(1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
		for (int t = 0; t < 10; t++) send(t[0], 64'(t) << 17);
		send(1'b0, 64'h0);
		send(1'b0, 64'h1_0000);
		send(1'b1, 64'h5555_5555_5555_5555);
		send(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
		in_valid = 1'b0;

		apply_cfg(3'd3, MAP_WAY4, POL_LRU, 2'd1);
		quiet = 1;
		run_random(120);
		quiet = 0;
		run_random(180);
		apply_cfg(3'd4, MAP_WAY4, POL_RANDOM, 2'd1);
		hold_req = 1;
		run_random(300);
		apply_cfg(3'd6, MAP_WAY8, 2'd2, 2'd0);
		run_random(150);
		// let everything drain before going on
		wait (pending == 0);
		run_random(150);
		apply_cfg(3'd6, MAP_DIRECT, 2'd2, 2'd3);
		run_random(250);
		apply_cfg(3'd0, MAP_WAY8, 2'd3, 2'd2);
		run_random(300);
		apply_cfg(3'd7, MAP_WAY4, POL_RANDOM, 2'd0);
		run_random(300);
		apply_cfg(3'd6, MAP_FULL, POL_LRU, 2'd1);
		run_random(40);
		apply_cfg(3'd6, MAP_FULL, 2'd2, 2'd3);
		run_random(30);
		apply_cfg(3'd3, MAP_FULL, POL_RANDOM, 2'd2);
		run_random(6);

		waited = 0;
		while (pending != 0 && waited < 200_000) begin
			@(negedge clk);
			waited++;
		end
		repeat (100) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

@@ files.f @@
src/ctlr_pkg.sv
src/ctlr_ram.sv
src/ctlr_cfg.sv
src/ctlr_dir.sv
src/cache_tag_lookup_replacement.sv
bench/cache_tag_lookup_replacement_checker.sv
bench/cache_tag_lookup_replacement_tb.sv
